[rtl/cc20_pkg.sv]
// shared types, constants and state setup for the chacha20 stream cipher
// no dependencies
`default_nettype none

package cc20_pkg;

   localparam int DATA_W       = 64;
   localparam int COUNT_W      = 4;
   localparam int TDATA_W      = 72;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int BLOCK_WORDS  = 16;
   localparam int DOUBLE_ROUNDS = 10;
   localparam int ROUND_STEPS  = DOUBLE_ROUNDS * 4;
   localparam int STEP_W       = $clog2(ROUND_STEPS);
   localparam int POS_W        = 3;

   localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_3      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_HIGH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_CTR   = 3'd6;

   localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

   typedef logic [31:0] word_type;
   typedef logic [BLOCK_WORDS-1:0][31:0] block_type;
   typedef logic [3:0][63:0] key_type;

   typedef struct packed {
      logic load;
      logic round;
      logic finish;
      logic diag;
      logic second;
   } blk_ctrl_type;

   function automatic block_type build_init(input key_type key,
                                            input logic [63:0] nonce_lo,
                                            input logic [31:0] nonce_hi,
                                            input logic [31:0] ctr);
      block_type s;
      s[0] = SIGMA_0;
      s[1] = SIGMA_1;
      s[2] = SIGMA_2;
      s[3] = SIGMA_3;
      for (int i = 0; i < 4; i++) begin
         s[4 + 2 * i] = key[i][31:0];
         s[5 + 2 * i] = key[i][63:32];
      end
      s[12] = ctr;
      s[13] = nonce_lo[31:0];
      s[14] = nonce_lo[63:32];
      s[15] = nonce_hi;
      return s;
   endfunction

endpackage

`default_nettype wire

[rtl/chacha20_stream_cipher.sv]
// chacha20 stream cipher top level: csr registers, sequencer, output register
// depends on cc20_pkg and cc20_block
//
// req channel takes one word of up to eight message bytes (byte 0 in bits 7:0)
// with its byte count; rsp channel returns the same bytes xor keystream, bytes
// above the count zeroed, with the count (9..15 saturated to 8) and tlast copied.
// key, nonce and starting counter sit in csr registers written by csr_we.
// a word ends its message when tlast is set or it carries fewer than 8 bytes;
// the next word starts again at the configured counter.
// a word that opens a 64-byte keystream block runs the rounds on four half quarter
// round lanes, then the final add, then loads the output register; other words
// go straight to loading the output register.
// req_tready is high only while the sequencer is idle; one word at a time.
// the rsp register holds a finished word while rsp_tready is low and the next
// word may be accepted meanwhile; its result then waits in the sequencer.
// synchronous reset clears the registers to their defaults (counter 1) and
// empties the output register; the message state restarts.
`default_nettype none

module chacha20_stream_cipher
   import cc20_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TDATA_W-1:0]    req_tdata,  // data_in[63:0], byte_count[67:64]
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [TDATA_W-1:0]         rsp_tdata,  // data_out[63:0], out_byte_count[67:64]
   output logic                       rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ROUND = 2'd1;
   localparam logic [1:0] S_FINAL = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);

   logic [1:0]         state_ff, state_in;
   key_type            key_ff, key_in;
   logic [63:0]        nonce_lo_ff, nonce_lo_in;
   logic [31:0]        nonce_hi_ff, nonce_hi_in;
   logic [31:0]        init_ctr_ff, init_ctr_in;
   logic [31:0]        ctr_ff, ctr_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               in_msg_ff, in_msg_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept, emit_go;
   logic [31:0]        ctr_start, ctr_sel;
   logic [POS_W-1:0]   pos_start;
   logic [COUNT_W-1:0] count_sat;
   logic [DATA_W-1:0]  byte_mask, key_stream;
   block_type          init_state;
   blk_ctrl_type       blk_ctrl;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit_go    = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign count_sat  = req_tdata[DATA_W + COUNT_W - 1] ? FULL_COUNT
                                                       : req_tdata[DATA_W +: COUNT_W];
   assign ctr_start  = in_msg_ff ? ctr_ff : init_ctr_ff;
   assign pos_start  = in_msg_ff ? pos_ff : '0;
   assign ctr_sel    = (state_ff == S_IDLE) ? ctr_start : ctr_ff;
   assign init_state = build_init(key_ff, nonce_lo_ff, nonce_hi_ff, ctr_sel);

   always_comb begin
      blk_ctrl.load   = accept && (pos_start == '0);
      blk_ctrl.round  = (state_ff == S_ROUND);
      blk_ctrl.finish = (state_ff == S_FINAL);
      blk_ctrl.diag   = step_ff[1];
      blk_ctrl.second = step_ff[0];
   end

   cc20_block u_block (
      .clock      (clock),
      .ctrl       (blk_ctrl),
      .init_state (init_state),
      .word_sel   (pos_ff),
      .key_stream (key_stream)
   );

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[8 * i +: 8] = {8{COUNT_W'(i) < count_ff}};
      end
   end

   always_comb begin
      key_in      = key_ff;
      nonce_lo_in = nonce_lo_ff;
      nonce_hi_in = nonce_hi_ff;
      init_ctr_in = init_ctr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_0:      key_in[0]   = csr_wdata;
            CSR_KEY_1:      key_in[1]   = csr_wdata;
            CSR_KEY_2:      key_in[2]   = csr_wdata;
            CSR_KEY_3:      key_in[3]   = csr_wdata;
            CSR_NONCE_LOW:  nonce_lo_in = csr_wdata;
            CSR_NONCE_HIGH: nonce_hi_in = csr_wdata[31:0];
            CSR_INIT_CTR:   init_ctr_in = csr_wdata[31:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      pos_in       = pos_ff;
      in_msg_in    = in_msg_ff;
      step_in      = step_ff;
      data_in      = data_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               data_in   = req_tdata[DATA_W-1:0];
               count_in  = count_sat;
               last_in   = req_tlast;
               ctr_in    = ctr_start;
               pos_in    = pos_start;
               in_msg_in = 1'b1;
               step_in   = '0;
               state_in  = (pos_start == '0) ? S_ROUND : S_EMIT;
            end
         end
         S_ROUND: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            ctr_in   = ctr_ff + 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_data_in  = (data_ff ^ key_stream) & byte_mask;
               rsp_count_in = count_ff;
               rsp_last_in  = last_ff;
               rsp_valid_in = 1'b1;
               pos_in       = pos_ff + 1'b1;
               if (last_ff || (count_ff != FULL_COUNT)) begin
                  in_msg_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_ff       <= '0;
         nonce_lo_ff  <= '0;
         nonce_hi_ff  <= '0;
         init_ctr_ff  <= 32'd1;
         ctr_ff       <= '0;
         pos_ff       <= '0;
         in_msg_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         nonce_lo_ff  <= nonce_lo_in;
         nonce_hi_ff  <= nonce_hi_in;
         init_ctr_ff  <= init_ctr_in;
         ctr_ff       <= ctr_in;
         pos_ff       <= pos_in;
         in_msg_ff    <= in_msg_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      count_ff     <= count_in;
      last_ff      <= last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - DATA_W - COUNT_W){1'b0}}, rsp_count_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("sequencer took a word but stayed idle");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (step_ff <= LAST_STEP))
      else $error("round step counter ran past the last double round");

   a_ctr_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL) |=> (ctr_ff == $past(ctr_ff) + 32'd1))
      else $error("block counter did not advance after a block");

   a_block_at_boundary: assert property (@(posedge clock) disable iff (reset)
      (accept && (pos_start != '0)) |=> (state_ff == S_EMIT))
      else $error("mid-block word started a keystream block");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= FULL_COUNT))
      else $error("result byte count above eight");
`endif

endmodule

`default_nettype wire

[rtl/cc20_qr_half.sv]
// one half of a chacha quarter round: two add, xor, rotate steps
// depends on cc20_pkg
`default_nettype none

module cc20_qr_half
   import cc20_pkg::*;
(
   input  wire logic     second,
   input  wire word_type a_i,
   input  wire word_type b_i,
   input  wire word_type c_i,
   input  wire word_type d_i,
   output word_type      a_o,
   output word_type      b_o,
   output word_type      c_o,
   output word_type      d_o
);

   word_type a_sum, d_mix, c_sum, b_mix;

   always_comb begin
      a_sum = a_i + b_i;
      d_mix = d_i ^ a_sum;
      d_o   = second ? {d_mix[23:0], d_mix[31:24]} : {d_mix[15:0], d_mix[31:16]};
      c_sum = c_i + d_o;
      b_mix = b_i ^ c_sum;
      b_o   = second ? {b_mix[24:0], b_mix[31:25]} : {b_mix[19:0], b_mix[31:20]};
      a_o   = a_sum;
      c_o   = c_sum;
   end

endmodule

`default_nettype wire

[rtl/cc20_block.sv]
// chacha working state with four half quarter round lanes and final add
// depends on cc20_pkg and cc20_qr_half
`default_nettype none

module cc20_block
   import cc20_pkg::*;
(
   input  wire logic             clock,
   input  wire blk_ctrl_type     ctrl,
   input  wire block_type        init_state,
   input  wire logic [POS_W-1:0] word_sel,
   output logic [DATA_W-1:0]     key_stream
);

   block_type w_ff, w_in;
   logic [3:0] ia [4];
   logic [3:0] ib [4];
   logic [3:0] ic [4];
   logic [3:0] id [4];
   word_type   qa [4];
   word_type   qb [4];
   word_type   qc [4];
   word_type   qd [4];

   // column pass uses lane j as is, diagonal pass shifts b, c, d by 1, 2, 3
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         ia[j] = {2'b00, 2'(j)};
         ib[j] = {2'b01, 2'(j) + (ctrl.diag ? 2'd1 : 2'd0)};
         ic[j] = {2'b10, 2'(j) + (ctrl.diag ? 2'd2 : 2'd0)};
         id[j] = {2'b11, 2'(j) + (ctrl.diag ? 2'd3 : 2'd0)};
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_lane
      cc20_qr_half u_qr (
         .second (ctrl.second),
         .a_i    (w_ff[ia[j]]),
         .b_i    (w_ff[ib[j]]),
         .c_i    (w_ff[ic[j]]),
         .d_i    (w_ff[id[j]]),
         .a_o    (qa[j]),
         .b_o    (qb[j]),
         .c_o    (qc[j]),
         .d_o    (qd[j])
      );
   end

   always_comb begin
      w_in = w_ff;
      priority if (ctrl.load) begin
         w_in = init_state;
      end else if (ctrl.round) begin
         for (int j = 0; j < 4; j++) begin
            w_in[ia[j]] = qa[j];
            w_in[ib[j]] = qb[j];
            w_in[ic[j]] = qc[j];
            w_in[id[j]] = qd[j];
         end
      end else if (ctrl.finish) begin
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            w_in[i] = w_ff[i] + init_state[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign key_stream = {w_ff[{word_sel, 1'b1}], w_ff[{word_sel, 1'b0}]};

endmodule

`default_nettype wire

[bench/chacha20_stream_cipher_tb.sv]
// self-checking bench for chacha20_stream_cipher: a word-level keystream predictor
// in a small scoreboard, bursty sender, stalling receiver, several key/nonce setups
// depends on cc20_pkg and the chacha20_stream_cipher rtl

module chacha20_stream_cipher_tb;
   import cc20_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int PHASE_WORDS  = 216;

   typedef struct {
      bit [63:0] data;
      bit [3:0]  count;
      bit        last;
   } cipher_word_type;

   typedef enum {RX_STEADY, RX_RANDOM, RX_SPARSE, RX_PATTERN} rx_mode_type;

   class cipher_scoreboard;
      bit [63:0]       key [4];
      bit [63:0]       nonce_lo;
      bit [31:0]       nonce_hi;
      bit [31:0]       start_ctr;
      bit [31:0]       blk_ctr;
      bit [2:0]        pos;
      bit              active;
      bit [31:0]       ks [16];
      bit [31:0]       st [16];
      cipher_word_type pending [$];
      int              errors;
      int              checked;
      int              blocks;

      function new();
         foreach (key[i]) key[i] = '0;
         foreach (ks[i]) ks[i] = '0;
         nonce_lo  = '0;
         nonce_hi  = '0;
         start_ctr = 32'd1;
         blk_ctr   = '0;
         pos       = '0;
         active    = 1'b0;
         errors    = 0;
         checked   = 0;
         blocks    = 0;
      endfunction

      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [63:0] value);
         case (idx)
            CSR_KEY_0:      key[0] = value;
            CSR_KEY_1:      key[1] = value;
            CSR_KEY_2:      key[2] = value;
            CSR_KEY_3:      key[3] = value;
            CSR_NONCE_LOW:  nonce_lo = value;
            CSR_NONCE_HIGH: nonce_hi = value[31:0];
            CSR_INIT_CTR:   start_ctr = value[31:0];
            default: ;
         endcase
      endfunction

      function bit [31:0] rotl(bit [31:0] x, int n);
         return (x << n) | (x >> (32 - n));
      endfunction

      function void quarter(int a, int b, int c, int d);
         st[a] += st[b]; st[d] = rotl(st[d] ^ st[a], 16);
         st[c] += st[d]; st[b] = rotl(st[b] ^ st[c], 12);
         st[a] += st[b]; st[d] = rotl(st[d] ^ st[a], 8);
         st[c] += st[d]; st[b] = rotl(st[b] ^ st[c], 7);
      endfunction

      function void make_block();
         bit [31:0] init [16];
         init[0] = SIGMA_0;
         init[1] = SIGMA_1;
         init[2] = SIGMA_2;
         init[3] = SIGMA_3;
         for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = key[i][31:0];
            init[5 + 2 * i] = key[i][63:32];
         end
         init[12] = blk_ctr;
         init[13] = nonce_lo[31:0];
         init[14] = nonce_lo[63:32];
         init[15] = nonce_hi;
         st = init;
         for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
         end
         foreach (ks[i]) ks[i] = st[i] + init[i];
         blocks++;
      endfunction

      function void note_word(bit [63:0] data, bit [3:0] count, bit last);
         cipher_word_type w;
         bit [3:0]        n;
         bit [63:0]       mask;
         n = (count > FULL_COUNT) ? FULL_COUNT : count;
         if (!active) begin
            blk_ctr = start_ctr;
            pos = '0;
            active = 1'b1;
         end
         if (pos == 0) begin
            make_block();
            blk_ctr++;
         end
         mask = (n == FULL_COUNT) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
         w.data  = (data ^ {ks[2 * pos + 1], ks[2 * pos]}) & mask;
         w.count = n;
         w.last  = last;
         pending.push_back(w);
         pos++;
         if (last || n < FULL_COUNT) active = 1'b0;
      endfunction

      task report(string field, bit [63:0] got, bit [63:0] want);
         errors++;
         $display("result %0d: %s is %h, expected %h", checked, field, got, want);
      endtask

      task check_word(bit [63:0] data, bit [3:0] count, bit last);
         cipher_word_type w;
         checked++;
         if (pending.size() == 0) begin
            report("unexpected word", data, '0);
         end else begin
            w = pending.pop_front();
            if (data != w.data) report("data_out", data, w.data);
            if (count != w.count) report("out_byte_count", 64'(count), 64'(w.count));
            if (last != w.last) report("out_last", 64'(last), 64'(w.last));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata = '0;  // data_in[63:0], byte_count[67:64]
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;       // data_out[63:0], out_byte_count[67:64]
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cipher_scoreboard cipher_sb = new();

   int cycle_count = 0;
   int hold_request = 0;
   int burst_left = 0;
   int words_sent = 0;
   int messages_sent = 0;
   int setups = 1;

   chacha20_stream_cipher DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         cipher_sb.check_word(rsp_tdata[DATA_W-1:0], rsp_tdata[DATA_W+COUNT_W-1:DATA_W],
                              rsp_tlast);
      end
   end

   // receiver: stall modes of random length, plus a long hold-off when one is requested
   initial begin
      rx_mode_type rx_mode;
      int          mode_left;
      int          hold_left;
      rx_mode   = RX_STEADY;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_RANDOM: rsp_tready <= ($urandom_range(0, 1) == 0);
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
               default:   rsp_tready <= ((mode_left % 4) != 0);
            endcase
         end
      end
   end

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // called at a falling edge; returns at a falling edge with valid either still
   // up for the next word or already dropped after a gap
   task automatic send_word(input bit [63:0] data, input bit [3:0] count, input bit last);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(TDATA_W - DATA_W - COUNT_W){1'b0}}, count, data};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      cipher_sb.note_word(data, count, last);
      words_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (cipher_sb.pending.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input bit [CSR_IDX_W-1:0] idx, input bit [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      cipher_sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic program_regs(input bit [63:0] k0, input bit [63:0] k1,
                               input bit [63:0] k2, input bit [63:0] k3,
                               input bit [63:0] nlo, input bit [31:0] nhi,
                               input bit [31:0] ctr);
      csr_write(CSR_KEY_0, k0);
      csr_write(CSR_KEY_1, k1);
      csr_write(CSR_KEY_2, k2);
      csr_write(CSR_KEY_3, k3);
      csr_write(CSR_NONCE_LOW, nlo);
      csr_write(CSR_NONCE_HIGH, 64'(nhi));
      csr_write(CSR_INIT_CTR, 64'(ctr));
      csr_we <= 1'b0;
      setups++;
   endtask

   // full words, then one closing word of varied shape
   task automatic send_message(input int len);
      bit [3:0] count;
      bit       last;
      int       pick;
      for (int i = 0; i < len - 1; i++) send_word(rand64(), FULL_COUNT, 1'b0);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         count = FULL_COUNT;
         last  = 1'b1;
      end else if (pick < 8) begin
         count = 4'($urandom_range(1, 7));
         last  = 1'($urandom_range(0, 1));
      end else if (pick == 8) begin
         count = 4'($urandom_range(9, 15));
         last  = 1'b1;
      end else begin
         count = 4'd0;
         last  = 1'($urandom_range(0, 1));
      end
      send_word(rand64(), count, last);
      messages_sent++;
   endtask

   task automatic random_phase(input int upto);
      while (words_sent < upto) begin
         if ($urandom_range(0, 6) != 0) begin
            send_message(($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8));
         end else begin
            repeat ($urandom_range(1, 4))
               send_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
         end
      end
      drain();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: zero key, counter 1
      send_word('0, FULL_COUNT, 1'b0);
      send_word('1, FULL_COUNT, 1'b0);
      repeat (7) send_word(rand64(), FULL_COUNT, 1'b0);
      send_word(rand64(), FULL_COUNT, 1'b1);
      send_word(rand64(), 4'd0, 1'b0);
      send_word('1, 4'd15, 1'b0);
      send_word(rand64(), 4'd9, 1'b1);
      send_word(rand64(), 4'd1, 1'b0);
      send_word('1, 4'd7, 1'b1);
      send_word(rand64(), FULL_COUNT, 1'b0);
      send_word('1, 4'd0, 1'b1);
      send_word(rand64(), 4'd12, 1'b1);
      drain();

      // sequential key bytes, rfc style nonce, long receiver hold-off
      program_regs(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                   64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                   64'h4a000000_09000000, 32'h0, 32'h1);
      hold_request = 400;
      random_phase(words_sent + PHASE_WORDS);

      // all ones, counter wraps on the first block
      program_regs('1, '1, '1, '1, '1, '1, 32'hffff_ffff);
      random_phase(words_sent + PHASE_WORDS);

      program_regs('0, '0, '0, '0, '0, '0, 32'h0);
      random_phase(words_sent + PHASE_WORDS);

      program_regs(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, 32'hffff_fffe);
      random_phase(words_sent + PHASE_WORDS);

      program_regs(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, $urandom);
      random_phase(words_sent + PHASE_WORDS);

      repeat (50) @(posedge clock);
      $display("sent %0d words (%0d shaped messages) under %0d register setups, %0d blocks",
               words_sent, messages_sent, setups, cipher_sb.blocks);
      $display("results checked: %0d, failures: %0d", cipher_sb.checked, cipher_sb.errors);
      if (cipher_sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[chacha20_stream_cipher.f]
rtl/cc20_pkg.sv
rtl/cc20_qr_half.sv
rtl/cc20_block.sv
rtl/chacha20_stream_cipher.sv
bench/chacha20_stream_cipher_tb.sv
